// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- src/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants, codes and types of the lazy range-add range-sum tree.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int NODE_COUNT    = 4 * MAX_POSITIONS;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int POS_W         = 10;
    localparam int SIZE_W        = 11;
    localparam int VAL_W         = 63;
    localparam int BIT_W         = $clog2(VAL_W + 1);
    localparam int STACK_D       = NODE_W;
    localparam int SP_W          = $clog2(STACK_D + 1);
    localparam int IN_W          = ((2 * POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W         = ((VAL_W + 7) / 8) * 8;
    localparam int CFG_W         = 64;
    localparam int ADDR_W        = 4;

    localparam logic [VAL_W-1:0]  MOD_RESET  = {VAL_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_POSITIONS);

    localparam logic REG_MOD    = 1'b0;
    localparam logic REG_SIZE   = 1'b1;
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic {ALU_ADD, ALU_MUL} t_alu_op;

    typedef enum logic [1:0] {AL_IDLE, AL_FAST, AL_SER, AL_MLOOP} t_alu_st;

    typedef enum logic [1:0] {DST_OUT, DST_BASE, DST_ACC} t_alu_dst;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [VAL_W-1:0]  a;
        logic [VAL_W-1:0]  b;
        logic [SIZE_W-1:0] count;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              right;
    } t_frame;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_VRED, ST_VRED_W, ST_VISIT, ST_LOAD,
        ST_PMUL, ST_PMUL_W, ST_PADD, ST_PADD_W,
        ST_KID_RD, ST_KID_LD, ST_KID_W, ST_CHECK,
        ST_QADD, ST_QADD_W, ST_CMUL, ST_CMUL_W, ST_CADD, ST_CADD_W,
        ST_RET, ST_SUM_RD, ST_SUM_RD2, ST_SUM_LD, ST_SUM_W, ST_OUT
    } t_st;

endpackage

// ----- src/lrs_ram.sv -----
// ----------------------------------------------------------------------------
// lrs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lrs_alu.sv -----
// ----------------------------------------------------------------------------
// lrs_alu
// Shared modular unit: (a + b) mod m, and (count * b) mod m by double-and-add.
// ----------------------------------------------------------------------------
module lrs_alu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lrs_pkg::VAL_W-1:0] i_mod,
    input  lrs_pkg::t_alu_req         i_req,
    output lrs_pkg::t_alu_rsp         o_rsp
);
    import lrs_pkg::*;

    t_alu_st           r_state, n_state;
    t_alu_dst          r_dst, n_dst;
    logic [VAL_W:0]    r_x, n_x;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [SIZE_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0]  r_base, n_base;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic [VAL_W-1:0]  r_res, n_res;
    logic              r_done, n_done;

    logic [VAL_W+1:0]  w_diff;
    logic [VAL_W:0]    w_shl, w_shl_sub, w_modx;
    logic              w_ge_x, w_ge_d, w_ge_s, w_slow, w_got;
    logic [VAL_W-1:0]  w_val;

    always_comb begin
        w_modx    = {1'b0, i_mod};
        w_diff    = {1'b0, r_x} - {2'b0, i_mod};
        w_shl     = {r_rem, r_x[r_bit]};
        w_shl_sub = w_shl - w_modx;
        w_ge_x    = r_x >= w_modx;
        w_ge_d    = w_diff[VAL_W:0] >= w_modx;
        w_ge_s    = w_shl >= w_modx;
        w_slow    = w_ge_x && w_ge_d;
        w_got     = ((r_state == AL_FAST) && !w_slow) ||
                    ((r_state == AL_SER) && (r_bit == '0));
        if (r_state == AL_SER) begin
            w_val = w_ge_s ? w_shl_sub[VAL_W-1:0] : w_shl[VAL_W-1:0];
        end else begin
            w_val = w_ge_x ? w_diff[VAL_W-1:0] : r_x[VAL_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            AL_IDLE: begin
                if (i_req.start) n_state = AL_FAST;
            end
            AL_FAST, AL_SER: begin
                if (r_state == AL_FAST && w_slow) begin
                    n_state = AL_SER;
                end else if (w_got) begin
                    case (r_dst)
                        DST_OUT:  n_state = AL_IDLE;
                        DST_BASE: n_state = AL_MLOOP;
                        DST_ACC:  n_state = AL_FAST;
                        default:  n_state = AL_IDLE;
                    endcase
                end
            end
            AL_MLOOP: begin
                n_state = (r_cnt == '0) ? AL_IDLE : AL_FAST;
            end
            default: n_state = AL_IDLE;
        endcase
    end

    always_comb begin
        n_dst  = r_dst;
        n_x    = r_x;
        n_rem  = r_rem;
        n_bit  = r_bit;
        n_cnt  = r_cnt;
        n_base = r_base;
        n_acc  = r_acc;
        n_res  = r_res;
        n_done = 1'b0;
        case (r_state)
            AL_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == ALU_ADD) begin
                        n_x   = {1'b0, i_req.a} + {1'b0, i_req.b};
                        n_dst = DST_OUT;
                    end else begin
                        n_x   = {1'b0, i_req.b};
                        n_dst = DST_BASE;
                        n_cnt = i_req.count;
                        n_acc = '0;
                    end
                end
            end
            AL_FAST, AL_SER: begin
                if (r_state == AL_FAST && w_slow) begin
                    n_rem = '0;
                    n_bit = BIT_W'(VAL_W);
                end else if (r_state == AL_SER && r_bit != '0) begin
                    n_rem = w_val;
                    n_bit = r_bit - 1'b1;
                end
                if (w_got) begin
                    case (r_dst)
                        DST_OUT: begin
                            n_res  = w_val;
                            n_done = 1'b1;
                        end
                        DST_BASE: n_base = w_val;
                        DST_ACC: begin
                            n_acc = w_val;
                            n_x   = {r_base, 1'b0};
                            n_cnt = r_cnt >> 1;
                            n_dst = DST_BASE;
                        end
                        default: n_res = w_val;
                    endcase
                end
            end
            AL_MLOOP: begin
                if (r_cnt == '0) begin
                    n_res  = r_acc;
                    n_done = 1'b1;
                end else if (r_cnt[0]) begin
                    n_x   = {1'b0, r_acc} + {1'b0, r_base};
                    n_dst = DST_ACC;
                end else begin
                    n_x   = {r_base, 1'b0};
                    n_cnt = r_cnt >> 1;
                    n_dst = DST_BASE;
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AL_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_dst  <= n_dst;
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

// ----- src/lazy_range_add_range_sum_tree.sv -----
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_tree
// Lazy segment tree with modular range add and range sum over 1024 positions.
// ----------------------------------------------------------------------------
// One request at a time: s_axis_tready is high only while the block is idle,
// and each request returns one result (the modular range sum for a query,
// zero for an add). After reset the block zeroes all 4096 entries of both
// node stores before it takes the first request. A request walks the tree
// with an explicit stack, about four nodes per level; each node costs a few
// RAM accesses plus calls to the shared modular unit, which adds with one
// reduction step and multiplies by a span length by double-and-add over
// its bits. Sums of at least twice the modulus (first reduction of an added
// value, or stored values after a modulus change) take a further bit-serial
// reduction.
module lazy_range_add_range_sum_tree (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lrs_pkg::IN_W-1:0]    s_axis_tdata,  // range_low, range_high, add_value
    input  logic                        s_axis_tuser,  // mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lrs_pkg::OUT_W-1:0]   m_axis_tdata,  // range_sum
    output logic                        m_axis_tuser,  // is_query_reply
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrs_pkg::ADDR_W-1:0]  paddr,
    input  logic [lrs_pkg::CFG_W-1:0]   pwdata,
    output logic [lrs_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);
    import lrs_pkg::*;

    t_st               r_state, n_state;
    logic [NODE_W-1:0] r_clr;
    logic [VAL_W-1:0]  r_mod;
    logic [SIZE_W-1:0] r_size;
    logic              r_mode;
    logic [POS_W-1:0]  r_a, r_b;
    logic [VAL_W-1:0]  r_v, r_acc, r_s, r_p, r_t, r_pv;
    logic [NODE_W-1:0] r_node;
    logic [POS_W-1:0]  r_lo, r_hi;
    logic              r_kid, r_kid_ret;
    logic [SP_W-1:0]   r_sp;
    t_frame            r_stk [STACK_D];

    logic [VAL_W-1:0]  n_v, n_acc, n_s, n_p, n_t, n_pv;
    logic [NODE_W-1:0] n_node;
    logic [POS_W-1:0]  n_lo, n_hi;
    logic              n_kid, n_kid_ret;
    logic [SP_W-1:0]   n_sp;

    logic              w_cfg_wr, w_in_acc, w_done;
    logic [VAL_W-1:0]  w_m;
    logic [SIZE_W-1:0] w_n, w_len, w_lh, w_tlh;
    logic [POS_W-1:0]  w_mid, w_tmid, w_in_lo, w_in_hi;
    logic [SP_W-1:0]   w_top_idx;
    t_frame            w_top;
    logic [NODE_W-1:0] w_kid_addr;
    logic              w_kids_fit, w_kid_ok, w_disjoint, w_covered;
    logic              w_push, w_mark;

    t_alu_req          w_req;
    t_alu_rsp          w_rsp;

    logic              w_ns_we, w_pd_we;
    logic [NODE_W-1:0] w_ns_waddr, w_pd_waddr, w_ns_raddr, w_pd_raddr;
    logic [VAL_W-1:0]  w_ns_wdata, w_pd_wdata, w_ns_q, w_pd_q;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[3] == REG_SIZE) ? CFG_W'(r_size) : CFG_W'(r_mod);

    always_comb begin
        w_m = (r_mod == '0) ? VAL_W'(1) : r_mod;
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_POSITIONS)) begin
            w_n = SIZE_W'(MAX_POSITIONS);
        end else begin
            w_n = r_size;
        end
        w_in_lo    = s_axis_tdata[POS_W-1:0];
        w_in_hi    = s_axis_tdata[2*POS_W-1:POS_W];
        w_in_acc   = s_axis_tvalid && s_axis_tready;
        w_done     = w_rsp.done;
        w_len      = {1'b0, r_hi} - {1'b0, r_lo} + SIZE_W'(1);
        w_lh       = {1'b0, r_lo} + {1'b0, r_hi};
        w_mid      = w_lh[SIZE_W-1:1];
        w_top_idx  = r_sp - 1'b1;
        w_top      = r_stk[w_top_idx];
        w_tlh      = {1'b0, w_top.lo} + {1'b0, w_top.hi};
        w_tmid     = w_tlh[SIZE_W-1:1];
        w_kid_addr = {r_node[NODE_W-2:0], r_kid};
        w_kids_fit = {1'b0, r_node, 1'b1} < (NODE_W+2)'(NODE_COUNT);
        w_kid_ok   = (r_lo != r_hi) && w_kids_fit;
        w_disjoint = (r_lo > r_b) || (r_hi < r_a);
        w_covered  = (r_a <= r_lo) && (r_hi <= r_b);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (r_clr == NODE_W'(NODE_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_in_acc) n_state = (s_axis_tuser == MODE_QUERY) ? ST_VISIT : ST_VRED;
            end
            ST_VRED:    n_state = ST_VRED_W;
            ST_VRED_W:  if (w_done) n_state = ST_VISIT;
            ST_VISIT:   n_state = ST_LOAD;
            ST_LOAD:    n_state = (w_pd_q != '0) ? ST_PMUL : ST_CHECK;
            ST_PMUL:    n_state = ST_PMUL_W;
            ST_PMUL_W:  if (w_done) n_state = ST_PADD;
            ST_PADD:    n_state = ST_PADD_W;
            ST_PADD_W:  if (w_done) n_state = w_kid_ok ? ST_KID_RD : ST_CHECK;
            ST_KID_RD:  n_state = ST_KID_LD;
            ST_KID_LD:  n_state = ST_KID_W;
            ST_KID_W: begin
                if (w_done) begin
                    if (!r_kid) n_state = ST_KID_RD;
                    else        n_state = r_kid_ret ? ST_RET : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_disjoint)       n_state = ST_RET;
                else if (w_covered)   n_state = (r_mode == MODE_QUERY) ? ST_QADD : ST_CMUL;
                else if (!w_kids_fit) n_state = ST_RET;
                else                  n_state = ST_VISIT;
            end
            ST_QADD:    n_state = ST_QADD_W;
            ST_QADD_W:  if (w_done) n_state = ST_RET;
            ST_CMUL:    n_state = ST_CMUL_W;
            ST_CMUL_W:  if (w_done) n_state = ST_CADD;
            ST_CADD:    n_state = ST_CADD_W;
            ST_CADD_W:  if (w_done) n_state = w_kid_ok ? ST_KID_RD : ST_RET;
            ST_RET: begin
                if (r_sp == '0)          n_state = ST_OUT;
                else if (!w_top.right)   n_state = ST_VISIT;
                else if (r_mode == MODE_ADD) n_state = ST_SUM_RD;
                else                     n_state = ST_RET;
            end
            ST_SUM_RD:  n_state = ST_SUM_RD2;
            ST_SUM_RD2: n_state = ST_SUM_LD;
            ST_SUM_LD:  n_state = ST_SUM_W;
            ST_SUM_W:   if (w_done) n_state = ST_RET;
            ST_OUT:     if (m_axis_tready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_v       = r_v;
        n_acc     = r_acc;
        n_s       = r_s;
        n_p       = r_p;
        n_t       = r_t;
        n_pv      = r_pv;
        n_node    = r_node;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_kid     = r_kid;
        n_kid_ret = r_kid_ret;
        n_sp      = r_sp;
        w_push    = 1'b0;
        w_mark    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_v    = s_axis_tdata[2*POS_W+VAL_W-1:2*POS_W];
                    n_acc  = '0;
                    n_sp   = '0;
                    n_node = NODE_W'(1);
                    n_lo   = '0;
                    n_hi   = POS_W'(w_n - SIZE_W'(1));
                end
            end
            ST_VRED_W:  if (w_done) n_v = w_rsp.result;
            ST_LOAD: begin
                n_s = w_ns_q;
                n_p = w_pd_q;
            end
            ST_PMUL_W:  if (w_done) n_t = w_rsp.result;
            ST_PADD_W: begin
                if (w_done) begin
                    n_s       = w_rsp.result;
                    n_kid     = 1'b0;
                    n_pv      = r_p;
                    n_kid_ret = 1'b0;
                end
            end
            ST_KID_W:   if (w_done) n_kid = 1'b1;
            ST_CHECK: begin
                if (!w_disjoint && !w_covered && w_kids_fit) begin
                    w_push = 1'b1;
                    n_sp   = r_sp + 1'b1;
                    n_node = {r_node[NODE_W-2:0], 1'b0};
                    n_hi   = w_mid;
                end
            end
            ST_QADD_W:  if (w_done) n_acc = w_rsp.result;
            ST_CMUL_W:  if (w_done) n_t = w_rsp.result;
            ST_CADD_W: begin
                if (w_done) begin
                    n_s       = w_rsp.result;
                    n_kid     = 1'b0;
                    n_pv      = r_v;
                    n_kid_ret = 1'b1;
                end
            end
            ST_RET: begin
                if (r_sp != '0) begin
                    if (!w_top.right) begin
                        w_mark = 1'b1;
                        n_node = {w_top.node[NODE_W-2:0], 1'b1};
                        n_lo   = w_tmid + 1'b1;
                        n_hi   = w_top.hi;
                    end else begin
                        n_sp   = r_sp - 1'b1;
                        n_node = w_top.node;
                    end
                end
            end
            ST_SUM_RD2: n_s = w_ns_q;
            default:    n_t = r_t;
        endcase
    end

    // unit requests and store ports
    always_comb begin
        w_req       = '0;
        w_req.op    = ALU_ADD;
        w_ns_raddr  = r_node;
        w_pd_raddr  = r_node;
        w_ns_we     = 1'b0;
        w_pd_we     = 1'b0;
        w_ns_waddr  = r_node;
        w_pd_waddr  = r_node;
        w_ns_wdata  = w_rsp.result;
        w_pd_wdata  = w_rsp.result;
        case (r_state)
            ST_CLEAR: begin
                w_ns_we    = 1'b1;
                w_pd_we    = 1'b1;
                w_ns_waddr = r_clr;
                w_pd_waddr = r_clr;
                w_ns_wdata = '0;
                w_pd_wdata = '0;
            end
            ST_VRED: begin
                w_req.start = 1'b1;
                w_req.a     = r_v;
            end
            ST_PMUL: begin
                w_req.start = 1'b1;
                w_req.op    = ALU_MUL;
                w_req.count = w_len;
                w_req.b     = r_p;
            end
            ST_PADD, ST_CADD: begin
                w_req.start = 1'b1;
                w_req.a     = r_s;
                w_req.b     = r_t;
            end
            ST_PADD_W: begin
                w_ns_we    = w_done;
                w_pd_we    = w_done;
                w_pd_wdata = '0;
            end
            ST_KID_RD:  w_pd_raddr = w_kid_addr;
            ST_KID_LD: begin
                w_req.start = 1'b1;
                w_req.a     = w_pd_q;
                w_req.b     = r_pv;
            end
            ST_KID_W: begin
                w_pd_we    = w_done;
                w_pd_waddr = w_kid_addr;
            end
            ST_QADD: begin
                w_req.start = 1'b1;
                w_req.a     = r_acc;
                w_req.b     = r_s;
            end
            ST_CMUL: begin
                w_req.start = 1'b1;
                w_req.op    = ALU_MUL;
                w_req.count = w_len;
                w_req.b     = r_v;
            end
            ST_CADD_W, ST_SUM_W: w_ns_we = w_done;
            ST_SUM_RD:  w_ns_raddr = {r_node[NODE_W-2:0], 1'b0};
            ST_SUM_RD2: w_ns_raddr = {r_node[NODE_W-2:0], 1'b1};
            ST_SUM_LD: begin
                w_req.start = 1'b1;
                w_req.a     = r_s;
                w_req.b     = w_ns_q;
            end
            default: w_ns_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_mod   <= MOD_RESET;
            r_size  <= SIZE_RESET;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_cfg_wr) begin
                if (paddr[3] == REG_MOD) r_mod <= pwdata[VAL_W-1:0];
                else                     r_size <= pwdata[SIZE_W-1:0];
            end
        end
        if (w_in_acc) begin
            r_mode <= s_axis_tuser;
            r_a    <= (w_in_lo > w_in_hi) ? w_in_hi : w_in_lo;
            r_b    <= (w_in_lo > w_in_hi) ? w_in_lo : w_in_hi;
        end
        if (w_push) r_stk[r_sp] <= '{node: r_node, lo: r_lo, hi: r_hi, right: 1'b0};
        if (w_mark) r_stk[w_top_idx].right <= 1'b1;
        r_v       <= n_v;
        r_acc     <= n_acc;
        r_s       <= n_s;
        r_p       <= n_p;
        r_t       <= n_t;
        r_pv      <= n_pv;
        r_node    <= n_node;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_kid     <= n_kid;
        r_kid_ret <= n_kid_ret;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = OUT_W'(r_acc);
    assign m_axis_tuser  = r_mode;

    lrs_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (w_m),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    lrs_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_ns_we),
        .i_waddr (w_ns_waddr),
        .i_wdata (w_ns_wdata),
        .i_raddr (w_ns_raddr),
        .o_rdata (w_ns_q)
    );

    lrs_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_pend (
        .i_clk   (i_clk),
        .i_we    (w_pd_we),
        .i_waddr (w_pd_waddr),
        .i_wdata (w_pd_wdata),
        .i_raddr (w_pd_raddr),
        .o_rdata (w_pd_q)
    );

endmodule

// ----- src/lrs_checker.sv -----
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks of the tree block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [lrs_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic                       m_axis_tuser
);

    `AST_IMP(a_one_in_flight, s_axis_tready, !m_axis_tvalid)
    `AST_NXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `AST_IMP(a_add_ack_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind lazy_range_add_range_sum_tree lrs_checker u_lrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_lazy_range_add_range_sum_tree.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lazy_range_add_range_sum_tree
// Self-checking bench for the modular lazy range-add range-sum tree.
// ----------------------------------------------------------------------------
// A directed table covers reset contents, value and index extremes, reversed
// bounds, ranges past the size in use, zero modulus and size clamping. Random
// phases follow, each under its own register setting. Every request is fed to
// a tree predictor kept in step with the block; replies are checked in order.
// The request side sends in bursts with gaps; the reply side stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module tb_lazy_range_add_range_sum_tree;
    import lrs_pkg::*;

    localparam logic [63:0] MASK63   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          N_PHASES = 8;
    localparam int          PH_REQS  = 190;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        mode;      // request mode, or register index for ROW_CFG
        int          lo;
        int          hi;
        logic [63:0] val;       // add value, or register value for ROW_CFG
        bit          fixed;     // reply typed in below
        logic [62:0] fixed_sum;
    } t_row;

    typedef struct {
        logic [62:0] sum;
        logic        is_query;
    } t_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;   // range_low, range_high, add_value
    logic                s_axis_tuser;   // mode
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;   // range_sum
    logic                m_axis_tuser;   // is_query_reply
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [CFG_W-1:0]    pwdata;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    lazy_range_add_range_sum_tree u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // tree predictor state
    logic [63:0]  node_sum [NODE_COUNT];
    logic [63:0]  node_pend[NODE_COUNT];
    logic [63:0]  cur_modulus;
    logic [10:0]  cur_size_reg;

    t_reply       reply_q[$];
    int           mismatches;
    int           n_adds, n_queries, n_replies, n_cfg;
    int           burst_left;

    function automatic logic [63:0] eff_mod();
        return (cur_modulus == 0) ? 64'd1 : cur_modulus;
    endfunction

    function automatic int eff_size();
        if (cur_size_reg == 0) return 1;
        if (cur_size_reg > MAX_POSITIONS) return MAX_POSITIONS;
        return int'(cur_size_reg);
    endfunction

    function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b);
        return ((a & MASK63) + (b & MASK63)) % eff_mod();
    endfunction

    function automatic logic [63:0] mod_scale(int count, logic [63:0] v);
        logic [63:0] r;
        logic [63:0] base;
        int          c;
        r    = 0;
        base = (v & MASK63) % eff_mod();
        c    = count;
        while (c != 0) begin
            if (c[0]) r = mod_add(r, base);
            base = mod_add(base, base);
            c    = c >> 1;
        end
        return r;
    endfunction

    task automatic flush_pending(int lo, int hi, int nd);
        logic [63:0] p;
        if (nd < NODE_COUNT) begin
            p = node_pend[nd];
            if (p != 0) begin
                node_sum[nd] = mod_add(node_sum[nd], mod_scale(hi - lo + 1, p));
                if (lo != hi && 2 * nd + 1 < NODE_COUNT) begin
                    node_pend[2*nd]   = mod_add(node_pend[2*nd], p);
                    node_pend[2*nd+1] = mod_add(node_pend[2*nd+1], p);
                end
                node_pend[nd] = 0;
            end
        end
    endtask

    // walk the tree for one request; returns the range sum for a query
    task automatic tree_request(input logic mode, input int lo_in, input int hi_in,
                                input logic [63:0] add_in, output logic [62:0] sum);
        int          st_node[64];
        int          st_lo[64];
        int          st_hi[64];
        int          st_step[64];
        int          sp, nd, lo, hi, mid, step, a, b;
        logic [63:0] v, acc;
        a   = (lo_in <= hi_in) ? lo_in : hi_in;
        b   = (lo_in <= hi_in) ? hi_in : lo_in;
        v   = (add_in & MASK63) % eff_mod();
        acc = 0;
        sp  = 1;
        st_node[0] = 1; st_lo[0] = 0; st_hi[0] = eff_size() - 1; st_step[0] = 0;
        while (sp > 0) begin
            sp   = sp - 1;
            nd   = st_node[sp];
            lo   = st_lo[sp];
            hi   = st_hi[sp];
            step = st_step[sp];
            mid  = (lo + hi) / 2;
            if (step == 0) begin
                if (nd < NODE_COUNT) begin
                    flush_pending(lo, hi, nd);
                    if (!(lo > b || hi < a)) begin
                        if (a <= lo && hi <= b) begin
                            if (mode == MODE_QUERY) begin
                                acc = mod_add(acc, node_sum[nd] % eff_mod());
                            end else begin
                                node_sum[nd] = mod_add(node_sum[nd],
                                                       mod_scale(hi - lo + 1, v));
                                if (lo != hi && 2 * nd + 1 < NODE_COUNT) begin
                                    node_pend[2*nd]   = mod_add(node_pend[2*nd], v);
                                    node_pend[2*nd+1] = mod_add(node_pend[2*nd+1], v);
                                end
                            end
                        end else if (2 * nd + 1 < NODE_COUNT) begin
                            st_node[sp] = nd;   st_lo[sp] = lo; st_hi[sp] = hi;
                            st_step[sp] = 1;    sp = sp + 1;
                            st_node[sp] = 2*nd; st_lo[sp] = lo; st_hi[sp] = mid;
                            st_step[sp] = 0;    sp = sp + 1;
                        end
                    end
                end
            end else if (step == 1) begin
                st_node[sp] = nd;       st_lo[sp] = lo;      st_hi[sp] = hi;
                st_step[sp] = 2;        sp = sp + 1;
                st_node[sp] = 2*nd + 1; st_lo[sp] = mid + 1; st_hi[sp] = hi;
                st_step[sp] = 0;        sp = sp + 1;
            end else if (mode == MODE_ADD) begin
                node_sum[nd] = mod_add(node_sum[2*nd], node_sum[2*nd+1]);
            end
        end
        sum = acc[62:0];
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #800ms;
        $display("lazy_range_add_range_sum_tree verification failed");
        $finish;
    end

    // reply side: ready is always high, random, or on a periodic pattern, and the choice is redrawn at random
    initial begin
        int cyc;
        int style;
        m_axis_tready = 1'b0;
        cyc   = 0;
        style = 0;
        forever begin
            @(posedge i_clk);
            if (cyc % 64 == 0) style = $urandom_range(0, 3);
            case (style)
                0, 1: m_axis_tready <= 1'b1;
                2:    m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ((cyc % 8) < 2);
            endcase
            cyc++;
        end
    end

    // reply check: a handshake seen here completes at the next rising edge
    always @(negedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_replies++;
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: sum=%0d query=%0b",
                             m_axis_tdata[62:0], m_axis_tuser);
            end else begin
                want = reply_q.pop_front();
                if (m_axis_tdata[62:0] !== want.sum || m_axis_tuser !== want.is_query) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: expected sum=%0d query=%0b, got sum=%0d query=%0b",
                                 want.sum, want.is_query, m_axis_tdata[62:0], m_axis_tuser);
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [63:0] value);
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(idx == REG_MOD ? 0 : 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MOD) cur_modulus = value & MASK63;
        else cur_size_reg = value[10:0];
        n_cfg++;
    endtask

    task automatic send_request(input logic mode, input int lo, input int hi,
                                input logic [63:0] value, input bit fixed,
                                input logic [62:0] fixed_sum);
        int     gap;
        t_reply r;
        logic [62:0] s;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'd0, value[62:0], 10'(hi), 10'(lo)};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        tree_request(mode, lo, hi, value, s);
        r.is_query = mode;
        r.sum      = (mode == MODE_QUERY) ? (fixed ? fixed_sum : s) : 63'd0;
        reply_q.push_back(r);
        if (mode == MODE_QUERY) n_queries++;
        else n_adds++;
    endtask

    function automatic int rand_pos(int n);
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, n - 1);
        return $urandom_range(0, 1023);
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 4))
            0:       return 64'($urandom_range(0, 1000));
            1:       return MASK63;
            default: return {$urandom, $urandom} & MASK63;
        endcase
    endfunction

    t_row dir_rows[] = '{
        '{ROW_REQ, MODE_QUERY, 0, 1023, 64'd0, 1'b1, 63'd0},
        '{ROW_REQ, MODE_ADD, 0, 1023, MASK63, 1'b1, 63'd0},
        '{ROW_REQ, MODE_QUERY, 1023, 0, 64'd0, 1'b1, 63'd0},
        '{ROW_REQ, MODE_ADD, 5, 5, 64'd7, 1'b1, 63'd0},
        '{ROW_REQ, MODE_QUERY, 5, 5, 64'd0, 1'b1, 63'd7},
        '{ROW_REQ, MODE_ADD, 10, 3, 64'd1, 1'b0, 63'd0},
        '{ROW_REQ, MODE_QUERY, 1023, 0, 64'd0, 1'b0, 63'd0},
        '{ROW_REQ, MODE_ADD, 1023, 1023, MASK63 - 1, 1'b0, 63'd0},
        '{ROW_REQ, MODE_QUERY, 1023, 1023, 64'd0, 1'b1, 63'h7FFF_FFFF_FFFF_FFFE},
        '{ROW_REQ, MODE_QUERY, 1022, 1023, 64'd0, 1'b0, 63'd0},
        '{ROW_REQ, MODE_ADD, 0, 1023, 64'h5A5A_A5A5_1234_8765, 1'b0, 63'd0},
        '{ROW_REQ, MODE_QUERY, 512, 513, 64'd0, 1'b0, 63'd0},
        '{ROW_REQ, MODE_ADD, 0, 0, 64'd0, 1'b0, 63'd0},
        '{ROW_CFG, REG_SIZE, 0, 0, 64'd16, 1'b0, 63'd0},
        '{ROW_REQ, MODE_ADD, 20, 1023, 64'd5, 1'b0, 63'd0},
        '{ROW_REQ, MODE_QUERY, 20, 30, 64'd0, 1'b1, 63'd0},
        '{ROW_REQ, MODE_QUERY, 30, 10, 64'd0, 1'b0, 63'd0},
        '{ROW_CFG, REG_MOD, 0, 0, 64'd1000003, 1'b0, 63'd0},
        '{ROW_REQ, MODE_QUERY, 0, 15, 64'd0, 1'b0, 63'd0},
        '{ROW_CFG, REG_MOD, 0, 0, 64'd0, 1'b0, 63'd0},
        '{ROW_REQ, MODE_ADD, 0, 7, 64'd99, 1'b1, 63'd0},
        '{ROW_REQ, MODE_QUERY, 0, 1023, 64'd0, 1'b1, 63'd0},
        '{ROW_CFG, REG_SIZE, 0, 0, 64'd2047, 1'b0, 63'd0},
        '{ROW_CFG, REG_MOD, 0, 0, MASK63, 1'b0, 63'd0},
        '{ROW_REQ, MODE_QUERY, 0, 1023, 64'd0, 1'b0, 63'd0}
    };

    initial begin
        int          n, lo, hi;
        logic [63:0] m;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        n_adds        = 0;
        n_queries     = 0;
        n_replies     = 0;
        n_cfg         = 0;
        burst_left    = 0;
        cur_modulus   = MASK63;
        cur_size_reg  = SIZE_RESET;
        for (int i = 0; i < NODE_COUNT; i++) begin
            node_sum[i]  = 0;
            node_pend[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].mode, dir_rows[i].val);
            else
                send_request(dir_rows[i].mode, dir_rows[i].lo, dir_rows[i].hi,
                             dir_rows[i].val, dir_rows[i].fixed, dir_rows[i].fixed_sum);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: m = MASK63 - 64'($urandom_range(0, 3));
                1: m = 64'($urandom_range(2, 100));
                2: m = ({$urandom, $urandom} & MASK63) | 64'h4000_0000_0000_0000;
                default: m = (ph == 3) ? 64'd1 : 64'd0;
            endcase
            write_reg(REG_MOD, m);
            case (ph)
                0: write_reg(REG_SIZE, 64'd1);
                1: write_reg(REG_SIZE, 64'd1024);
                2: write_reg(REG_SIZE, 64'd0);
                3: write_reg(REG_SIZE, 64'd2047);
                default: write_reg(REG_SIZE, 64'($urandom_range(2, 1100)));
            endcase
            n = eff_size();
            for (int k = 0; k < PH_REQS; k++) begin
                lo = rand_pos(n);
                hi = ($urandom_range(0, 3) == 0) ? lo : rand_pos(n);
                send_request(logic'($urandom_range(0, 1)), lo, hi, rand_value(),
                             1'b0, 63'd0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d adds and %0d queries, %0d replies, %0d register writes",
                 n_adds, n_queries, n_replies, n_cfg);
        $display("register phases: moduli from 0 to 2^63-1, sizes 0, 1, 16, 1024, 2047");
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("lazy_range_add_range_sum_tree verification clean");
        end else begin
            $display("mismatches: %0d, replies still owed: %0d", mismatches, reply_q.size());
            $display("lazy_range_add_range_sum_tree verification failed");
        end
        $finish;
    end

endmodule
